### rtl/core/iol_pkg.sv
// Shared types and constants for the indexed ordered list core.
// No dependencies; imported by the interfaces, the cell and the top level.
package iol_pkg;

   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 32;
   localparam int MODE_W         = 3;
   localparam int POS_W          = 5;
   localparam int VAL_W          = 32;
   localparam int STATUS_W       = 2;
   localparam int SIZE_W         = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_BACK  = 3'd0,
      MODE_PUSH_FRONT = 3'd1,
      MODE_POP_BACK   = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_INSERT     = 3'd4,
      MODE_ERASE      = 3'd5,
      MODE_READ       = 3'd6,
      MODE_CLEAR      = 3'd7
   } iol_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_EMPTY = 2'd3
   } iol_status_type;

   // insert: cells above the slot take their lower neighbor, the slot takes the new value
   // delete: cells at and above the slot take their upper neighbor
   typedef enum logic [1:0] {
      SHIFT_NONE = 2'd0,
      SHIFT_INS  = 2'd1,
      SHIFT_DEL  = 2'd2
   } iol_shift_type;

endpackage

### rtl/core/iol_if.sv
// Request and response channel interfaces for the indexed ordered list core.
// Depends on iol_pkg for field widths.
interface iol_req_if import iol_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [POS_W-1:0]  position;
   logic [VAL_W-1:0]  item_value;

   modport source (output valid, mode, position, item_value, input ready);
   modport sink   (input valid, mode, position, item_value, output ready);
endinterface

interface iol_rsp_if import iol_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VAL_W-1:0]    read_value;
   logic [STATUS_W-1:0] status;
   logic [SIZE_W-1:0]   list_size;
   logic                is_empty;

   modport source (output valid, read_value, status, list_size, is_empty, input ready);
   modport sink   (input valid, read_value, status, list_size, is_empty, output ready);
endinterface

### rtl/core/indexed_ordered_list_core.sv
// Top level of the indexed ordered list: decode, count and a chain of iol_cell.
// Depends on iol_pkg, iol_req_if / iol_rsp_if and iol_cell.
//
//   channel | dir | fields
//   req_ch  | in  | mode, position, item_value
//   rsp_ch  | out | read_value, status, list_size, is_empty
//
// One item per cycle unless stalled; each response is valid in the next cycle.
// All cells shift together in the accepting cycle, insert and erase alike.
// Synchronous reset clears the count and the response valid; cells are not cleared.
// A stalled response holds; req_ch.ready drops only while it waits.
module indexed_ordered_list_core import iol_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic     clock,
   input  logic     reset,
   iol_req_if.sink   req_ch,
   iol_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic [VAL_W-1:0]    read_value_ff;
   logic [VAL_W-1:0]    read_value_in;
   iol_status_type      status_ff;
   iol_status_type      status_in;

   iol_shift_type       shift_kind;
   logic [CNT_W-1:0]    shift_at;
   logic [DATA_WIDTH-1:0] new_value;

   iol_mode_type        mode;
   logic [CMP_W-1:0]    pos_cmp;
   logic [CMP_W-1:0]    count_cmp;
   logic                accept;
   logic [63:0]         read_wide;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign mode         = iol_mode_type'(req_ch.mode);
   assign pos_cmp      = CMP_W'(req_ch.position);
   assign count_cmp    = CMP_W'(count_ff);
   assign new_value    = DATA_WIDTH'(req_ch.item_value);
   assign read_wide    = 64'(cell_q[pos_cmp[IDX_W-1:0]]);

   always_comb begin
      count_in      = count_ff;
      status_in     = STATUS_OK;
      read_value_in = '0;
      shift_kind    = SHIFT_NONE;
      shift_at      = '0;
      case (mode)
         MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
            if (count_ff == FULL_COUNT) begin
               status_in = STATUS_FULL;
            end else begin
               shift_kind = SHIFT_INS;
               shift_at   = (mode == MODE_PUSH_BACK) ? count_ff : '0;
               count_in   = count_ff + 1'b1;
            end
         end
         MODE_POP_BACK: begin
            if (count_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         MODE_POP_FRONT: begin
            if (count_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else begin
               shift_kind = SHIFT_DEL;
               count_in   = count_ff - 1'b1;
            end
         end
         MODE_INSERT: begin
            if (pos_cmp > count_cmp) begin
               status_in = STATUS_RANGE;
            end else if (count_ff == FULL_COUNT) begin
               status_in = STATUS_FULL;
            end else begin
               shift_kind = SHIFT_INS;
               shift_at   = CNT_W'(pos_cmp);
               count_in   = count_ff + 1'b1;
            end
         end
         MODE_ERASE: begin
            if (pos_cmp >= count_cmp) begin
               status_in = STATUS_RANGE;
            end else begin
               shift_kind = SHIFT_DEL;
               shift_at   = CNT_W'(pos_cmp);
               count_in   = count_ff - 1'b1;
            end
         end
         MODE_READ: begin
            if (pos_cmp >= count_cmp) begin
               status_in = STATUS_RANGE;
            end else begin
               read_value_in = read_wide[VAL_W-1:0];
            end
         end
         MODE_CLEAR: count_in = '0;
         default:    count_in = count_ff;
      endcase
      if (!accept) begin
         count_in   = count_ff;
         shift_kind = SHIFT_NONE;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_value;
         logic [DATA_WIDTH-1:0] right_value;
         if (gi == 0) begin : g_left_edge
            assign left_value = '0;
         end else begin : g_left
            assign left_value = cell_q[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_right_edge
            assign right_value = '0;
         end else begin : g_right
            assign right_value = cell_q[gi+1];
         end
         iol_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (gi)
         ) u_cell (
            .clock       (clock),
            .shift_kind  (shift_kind),
            .shift_at    (shift_at),
            .left_value  (left_value),
            .right_value (right_value),
            .new_value   (new_value),
            .cell_value  (cell_q[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         read_value_ff <= read_value_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = read_value_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.list_size  = SIZE_W'(count_ff);
   assign rsp_ch.is_empty   = (count_ff == '0);

endmodule

### rtl/core/iol_cell.sv
// One storage cell of the list chain; shifts with its neighbors on insert/delete.
// Depends on iol_pkg.
module iol_cell import iol_pkg::*; #(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  iol_shift_type         shift_kind,
   input  logic [CNT_W-1:0]      shift_at,
   input  logic [DATA_WIDTH-1:0] left_value,
   input  logic [DATA_WIDTH-1:0] right_value,
   input  logic [DATA_WIDTH-1:0] new_value,
   output logic [DATA_WIDTH-1:0] cell_value
);

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (shift_kind)
         SHIFT_INS: begin
            if (MY_INDEX > shift_at) begin
               value_in = left_value;
            end else if (MY_INDEX == shift_at) begin
               value_in = new_value;
            end
         end
         SHIFT_DEL: begin
            if (MY_INDEX >= shift_at) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;

endmodule
